@@ design/range_paint_and_color_count_top_macros.svh @@
// Assertion macros for the range paint and color count block.
// Used by the top level; defining ASSERT_OFF turns every check into nothing.
`ifndef RANGE_PAINT_AND_COLOR_COUNT_TOP_MACROS_SVH
`define RANGE_PAINT_AND_COLOR_COUNT_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// The condition must hold at every clock edge outside reset.
`define RPCC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// The consequence must hold in the cycle after the trigger.
`define RPCC_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);
`else
`define RPCC_ASSERT_ALWAYS(label, cond, msg)
`define RPCC_ASSERT_NEXT(label, trig, cons, msg)
`endif
`endif

@@ design/rpcc_pkg.sv @@
// Shared field widths, command codes and types of the range paint and color count block.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package rpcc_pkg;

    // Fixed widths of the transfer fields and of the length register.
    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 10;
    localparam int COLOR_W  = 31;
    localparam int LENGTH_W = 11;
    localparam int COUNT_W  = 11;

    typedef logic [CMD_W-1:0]    cmd_code_t;
    typedef logic [INDEX_W-1:0]  index_t;
    typedef logic [COLOR_W-1:0]  color_t;
    typedef logic [LENGTH_W-1:0] length_t;
    typedef logic [COUNT_W-1:0]  count_t;

    // Command codes; the fourth code is ignored.
    localparam cmd_code_t CMD_LOAD  = 2'd0;
    localparam cmd_code_t CMD_PAINT = 2'd1;
    localparam cmd_code_t CMD_COUNT = 2'd2;

    // Length in use after reset.
    localparam length_t LENGTH_RESET = 11'd1024;

endpackage

`default_nettype wire

@@ design/rpcc_ifs.sv @@
// Valid/ready channel interfaces: commands in, counts out.
// Depends on rpcc_pkg for the payload types.
`default_nettype none

interface rpcc_cmd_if
    import rpcc_pkg::*;
();
    logic      valid;
    logic      ready;
    cmd_code_t command;
    index_t    left_index;
    index_t    right_index;
    color_t    color_value;

    modport source (output valid, output command, output left_index,
                    output right_index, output color_value, input ready);
    modport sink   (input valid, input command, input left_index,
                    input right_index, input color_value, output ready);
endinterface

interface rpcc_cnt_if
    import rpcc_pkg::*;
();
    logic   valid;
    logic   ready;
    count_t range_count;

    modport source (output valid, output range_count, input ready);
    modport sink   (input valid, input range_count, output ready);
endinterface

`default_nettype wire

@@ design/range_paint_and_color_count_top.sv @@
// Top level of the range paint and color count block: command sequencer, block flags
// and the cell RAM. Depends on rpcc_pkg, rpcc_ifs, rpcc_ram and the assertion macros.
//
//   Channel   Direction  Handshake       Payload
//   cmd       in         valid/ready     command, left_index, right_index, color_value
//   result    out        valid/ready     range_count (count commands only)
//   cfg       in         cfg_wr_en       cfg_wr_data = length in use
//
// Per command: an idle and a set-up state, then per block a flag step, plus a sweep over
// every cell to expand a uniform block, or over the cells in range of a mixed block.
// A count adds a drain state after a final scan and a hand-over state.
// No clearing pass: a block's cells are read only after its expansion wrote them all.
// A waiting result stalls only the hand-over of the next count; the RAM port sets the pace.
`default_nettype none

`include "range_paint_and_color_count_top_macros.svh"

module range_paint_and_color_count_top
    import rpcc_pkg::*;
#(
    parameter int CELL_COUNT  = 1024,
    parameter int BLOCK_WORDS = 32
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cfg_wr_en,
    input  wire length_t cfg_wr_data,
    rpcc_cmd_if.sink     cmd,
    rpcc_cnt_if.source   result
);

    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int NUM_BLOCKS = (CELL_COUNT + BLOCK_WORDS - 1) / BLOCK_WORDS;
    localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int LEN_W      = (ADDR_W + 1 > LENGTH_W) ? ADDR_W + 1 : LENGTH_W;
    localparam int POS_W      = $clog2(CELL_COUNT + BLOCK_WORDS);
    localparam int SPAN_W     = ADDR_W + 1;
    // Block number by multiplying with a rounded-up reciprocal of BLOCK_WORDS.
    localparam int SHIFT_Q    = ADDR_W + $clog2(BLOCK_WORDS);
    localparam int RECIP_W    = ADDR_W + 1;
    localparam int PROD_W     = ADDR_W + RECIP_W;
    localparam longint unsigned RECIP_L =
        ((longint'(1) << SHIFT_Q) + longint'(BLOCK_WORDS) - 1) / longint'(BLOCK_WORDS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_BLOCK,
        ST_SWEEP,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Registers.
    state_t            state_reg,    state_next;
    length_t           length_reg;
    cmd_code_t         cmd_reg,      cmd_next;
    logic              valid_reg,    valid_next;
    logic [ADDR_W-1:0] l_reg,        l_next;
    logic [ADDR_W-1:0] r_reg,        r_next;
    color_t            c_reg,        c_next;
    logic [BLK_W-1:0]  blk_reg,      blk_next;
    logic [ADDR_W-1:0] cell_reg,     cell_next;
    logic [ADDR_W-1:0] end_reg,      end_next;
    logic [ADDR_W-1:0] lo_reg,       lo_next;
    logic [ADDR_W-1:0] hi_reg,       hi_next;
    color_t            fill_reg,     fill_next;
    logic              last_blk_reg, last_blk_next;
    logic              rd_pend_reg,  rd_pend_next;
    count_t            total_reg,    total_next;
    logic              out_valid_reg, out_valid_next;
    count_t            out_count_reg, out_count_next;

    // Block flags, kept in flip-flops so reset sets them at once.
    logic   block_uniform_reg [NUM_BLOCKS];
    color_t block_color_reg   [NUM_BLOCKS];
    logic   blk_wr_en;
    logic   blk_wr_uniform;
    color_t blk_wr_color;

    // Cell RAM port.
    logic              ram_wr_en;
    color_t            ram_wr_data;
    logic              ram_rd_en;
    color_t            ram_rd_data;

    // Range check of an incoming command.
    logic [LEN_W-1:0] len_ext, eff_len, left_ext, right_ext, right_clamp;
    logic             len_ok, cmd_known, cmd_ok;

    always_comb
    begin
        len_ext   = LEN_W'(length_reg);
        eff_len   = (len_ext > LEN_W'(CELL_COUNT)) ? LEN_W'(CELL_COUNT) : len_ext;
        len_ok    = (eff_len != '0);
        left_ext  = LEN_W'(cmd.left_index);
        right_ext = (cmd.command == CMD_LOAD) ? left_ext : LEN_W'(cmd.right_index);
        right_clamp = (len_ok && (right_ext > eff_len - LEN_W'(1)))
                    ? eff_len - LEN_W'(1) : right_ext;
        cmd_known = (cmd.command == CMD_LOAD) || (cmd.command == CMD_PAINT)
                 || (cmd.command == CMD_COUNT);
        cmd_ok    = cmd_known && len_ok && (left_ext < eff_len) && (right_clamp >= left_ext);
    end

    // First block of the range from the registered left index.
    logic [PROD_W-1:0] quot_prod;
    logic [PROD_W-1:0] quot_full;

    assign quot_prod = PROD_W'(l_reg) * PROD_W'(RECIP);
    assign quot_full = quot_prod >> SHIFT_Q;

    // Geometry of the current block against the range.
    logic [POS_W-1:0]  blk_first, blk_end_raw, blk_last, l_pos, r_pos;
    logic [ADDR_W-1:0] blk_lo, blk_hi;
    logic [SPAN_W-1:0] blk_span;
    logic              blk_full, blk_is_last, blk_uni;
    color_t            blk_col;
    logic              scan_hit;

    always_comb
    begin
        blk_first   = POS_W'(POS_W'(blk_reg) * POS_W'(BLOCK_WORDS));
        blk_end_raw = blk_first + POS_W'(BLOCK_WORDS - 1);
        blk_last    = (blk_end_raw > POS_W'(CELL_COUNT - 1)) ? POS_W'(CELL_COUNT - 1)
                                                              : blk_end_raw;
        l_pos       = POS_W'(l_reg);
        r_pos       = POS_W'(r_reg);
        blk_full    = (l_pos <= blk_first) && (r_pos >= blk_last);
        blk_is_last = (blk_last >= r_pos);
        blk_lo      = (blk_first < l_pos) ? l_reg : ADDR_W'(blk_first);
        blk_hi      = (blk_last > r_pos) ? r_reg : ADDR_W'(blk_last);
        blk_span    = SPAN_W'(blk_hi) - SPAN_W'(blk_lo) + SPAN_W'(1);
        blk_uni     = block_uniform_reg[blk_reg];
        blk_col     = block_color_reg[blk_reg];
        scan_hit    = rd_pend_reg && (ram_rd_data == c_reg);
    end

    // Sequencer: next state and register values.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        valid_next     = valid_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        blk_next       = blk_reg;
        cell_next      = cell_reg;
        end_next       = end_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        fill_next      = fill_reg;
        last_blk_next  = last_blk_reg;
        rd_pend_next   = 1'b0;
        total_next     = total_reg + COUNT_W'(scan_hit);
        out_valid_next = out_valid_reg && !result.ready;
        out_count_next = out_count_reg;
        blk_wr_en      = 1'b0;
        blk_wr_uniform = 1'b0;
        blk_wr_color   = c_reg;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        ram_wr_data    = ((cell_reg >= lo_reg) && (cell_reg <= hi_reg)) ? c_reg : fill_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next   = cmd.command;
                    valid_next = cmd_ok;
                    l_next     = ADDR_W'(left_ext);
                    r_next     = ADDR_W'(right_clamp);
                    c_next     = cmd.color_value;
                    total_next = '0;
                    state_next = ST_START;
                end
            end

            ST_START:
            begin
                blk_next = BLK_W'(quot_full);
                if (valid_reg)
                begin
                    state_next = ST_BLOCK;
                end
                else if (cmd_reg == CMD_COUNT)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_BLOCK:
            begin
                last_blk_next = blk_is_last;
                lo_next       = blk_lo;
                hi_next       = blk_hi;
                if (cmd_reg == CMD_COUNT)
                begin
                    if (blk_uni)
                    begin
                        // A uniform block counts in one step.
                        if (blk_col == c_reg)
                        begin
                            total_next = total_reg + COUNT_W'(scan_hit)
                                       + COUNT_W'(blk_span);
                        end
                        if (blk_is_last)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            blk_next = blk_reg + BLK_W'(1);
                        end
                    end
                    else
                    begin
                        cell_next  = blk_lo;
                        end_next   = blk_hi;
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    priority if (blk_full || (blk_uni && (blk_col == c_reg)))
                    begin
                        // Whole block painted at once, or already the right color.
                        if (blk_full)
                        begin
                            blk_wr_en      = 1'b1;
                            blk_wr_uniform = 1'b1;
                        end
                        if (blk_is_last)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            blk_next = blk_reg + BLK_W'(1);
                        end
                    end
                    else if (blk_uni)
                    begin
                        // Expand the block and paint the part in range in one sweep.
                        blk_wr_en      = 1'b1;
                        blk_wr_uniform = 1'b0;
                        blk_wr_color   = blk_col;
                        fill_next      = blk_col;
                        cell_next      = ADDR_W'(blk_first);
                        end_next       = ADDR_W'(blk_last);
                        state_next     = ST_SWEEP;
                    end
                    else
                    begin
                        cell_next  = blk_lo;
                        end_next   = blk_hi;
                        state_next = ST_SWEEP;
                    end
                end
            end

            ST_SWEEP:
            begin
                ram_wr_en = 1'b1;
                if (cell_reg == end_reg)
                begin
                    if (last_blk_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        blk_next   = blk_reg + BLK_W'(1);
                        state_next = ST_BLOCK;
                    end
                end
                else
                begin
                    cell_next = cell_reg + ADDR_W'(1);
                end
            end

            ST_SCAN:
            begin
                ram_rd_en    = 1'b1;
                rd_pend_next = 1'b1;
                if (cell_reg == end_reg)
                begin
                    if (last_blk_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        blk_next   = blk_reg + BLK_W'(1);
                        state_next = ST_BLOCK;
                    end
                end
                else
                begin
                    cell_next = cell_reg + ADDR_W'(1);
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                // Hand the count to the output register once it is free.
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = total_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            length_reg    <= LENGTH_RESET;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_count_reg <= '0;
            valid_reg     <= 1'b0;
            last_blk_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            out_count_reg <= out_count_next;
            valid_reg     <= valid_next;
            last_blk_reg  <= last_blk_next;
            if (cfg_wr_en)
            begin
                length_reg <= cfg_wr_data;
            end
        end
    end

    // Payload and walk registers.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        l_reg         <= l_next;
        r_reg         <= r_next;
        c_reg         <= c_next;
        blk_reg       <= blk_next;
        cell_reg      <= cell_next;
        end_reg       <= end_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        fill_reg      <= fill_next;
        total_reg     <= total_next;
    end

    // Block flags: uniform and color per block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                block_uniform_reg[i] <= 1'b1;
                block_color_reg[i]   <= '0;
            end
        end
        else if (blk_wr_en)
        begin
            block_uniform_reg[blk_reg] <= blk_wr_uniform;
            block_color_reg[blk_reg]   <= blk_wr_color;
        end
    end

    // Cell store.
    rpcc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (CELL_COUNT)
    ) u_cell_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (cell_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (cell_reg),
        .rd_data (ram_rd_data)
    );

    // Channel handshakes.
    assign cmd.ready          = (state_reg == ST_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.range_count = out_count_reg;

    // Walk states for the checks below.
    logic in_scan;
    logic in_walk;

    assign in_scan = (state_reg == ST_SCAN);
    assign in_walk = (state_reg == ST_SWEEP) || in_scan;

    // Checks on the walk through blocks and cells.
    `RPCC_ASSERT_ALWAYS(a_walk_in_bounds, !in_walk || (cell_reg <= end_reg), "walk past its end")
    `RPCC_ASSERT_ALWAYS(a_scan_mixed_only, !in_scan || !blk_uni, "uniform block scanned")
    `RPCC_ASSERT_NEXT(a_scan_reads, in_scan, rd_pend_reg, "scan read not followed by a compare")

endmodule

`default_nettype wire

@@ design/rpcc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Stand-alone; no package needed.
`default_nettype none

module rpcc_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read; contents are not reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
